// ===== hdl/orderable_timestamp_codec_macros.svh =====
// Assertion macros shared by the orderable timestamp codec RTL.
`ifndef ORDERABLE_TIMESTAMP_CODEC_MACROS_SVH
`define ORDERABLE_TIMESTAMP_CODEC_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OTC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("orderable_timestamp_codec: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("orderable_timestamp_codec: next-cycle check failed");

`endif

// ===== hdl/otc_pkg.sv =====
// Package with the constants of the orderable timestamp codec.
package otc_pkg;

	localparam logic        OP_ENCODE       = 1'b0;
	localparam logic        OP_DECODE       = 1'b1;

	localparam logic [15:0] BASE_YEAR_RESET = 16'd2018;
	localparam logic [1:0]  INDICATOR       = 2'b10;
	localparam logic [3:0]  OFFSET_MAX      = 4'd15;
	localparam logic [5:0]  STEP_CAP        = 6'd32;
	localparam logic [5:0]  BIG_SHIFT       = 6'd8;
	localparam logic [5:0]  HALF_SHIFT      = 6'd16;
	localparam logic [5:0]  SMALL_BASE      = 6'd14;
	localparam logic [15:0] TOP_HALF_ONES   = 16'hffff;
	localparam logic [7:0]  PREFIX_ONES     = 8'hff;

endpackage

// ===== hdl/otc_if.sv =====
// Channel interfaces of the orderable timestamp codec.
interface otc_cmd_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] year_in;
	logic [3:0]  month_in;
	logic [4:0]  day_in;
	logic [4:0]  hour_in;
	logic [5:0]  minute_in;
	logic [5:0]  second_in;
	logic [31:0] code_in;

	modport source (output valid, op, year_in, month_in, day_in, hour_in, minute_in,
		second_in, code_in, input ready);
	modport sink (input valid, op, year_in, month_in, day_in, hour_in, minute_in,
		second_in, code_in, output ready);
endinterface

interface otc_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] code_out;
	logic [15:0] year_out;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [4:0]  hour_out;
	logic [5:0]  minute_out;
	logic [5:0]  second_out;
	logic        out_of_range;

	modport source (output valid, code_out, year_out, month_out, day_out, hour_out,
		minute_out, second_out, out_of_range, input ready);
	modport sink (input valid, code_out, year_out, month_out, day_out, hour_out,
		minute_out, second_out, out_of_range, output ready);
endinterface

interface otc_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] base_year;

	modport source (output valid, base_year, input ready);
	modport sink (input valid, base_year, output ready);
endinterface

// ===== hdl/orderable_timestamp_codec.sv =====
// Top level of the orderable timestamp codec.
// The codec turns calendar fields into a 32-bit code whose unsigned order follows time,
// and turns such a code back into fields. It is a three-stage pipeline: the first stage
// packs the fields or scans the code and works out the shift, the second applies it in
// one barrel shifter, and the third computes the decoded year and holds the result beat.
// Each stage has its own valid bit and stalls only when the stage after it is full, so
// one beat is taken per cycle while res.ready is high; results leave stage three.
// The base year register is written over the configuration channel, which is always
// ready; it must only be written while no command is in flight.
`include "orderable_timestamp_codec_macros.svh"

module orderable_timestamp_codec (
	input logic   clk,
	input logic   arst_n,
	otc_cmd_if.sink   cmd,
	otc_res_if.source res,
	otc_cfg_if.sink   cfg
);

	logic [15:0] base_year_q;

	logic        en1, en2, en3;

	logic        v_s1, op_s1, flag_s1;
	logic [31:0] word_s1;
	logic [5:0]  shamt_s1, n_s1;

	logic        v_s2, op_s2, flag_s2;
	logic [31:0] word_s2;
	logic [5:0]  n_s2;

	logic        v_s3, op_s3, flag_s3;
	logic [31:0] code_s3;
	logic [15:0] year_s3;
	logic [3:0]  month_s3;
	logic [4:0]  day_s3, hour_s3;
	logic [5:0]  minute_s3, second_s3;

	logic [16:0] diff;
	logic [12:0] steps_full;
	logic [5:0]  steps;
	logic        too_late;
	logic [3:0]  offset;
	logic [31:0] enc_word;
	logic [5:0]  enc_shamt;
	logic        top_ones, found_zero;
	logic [3:0]  zero_pos;
	logic [5:0]  dec_shamt, dec_n;
	logic        dec_flag;

	logic signed [31:0] enc_signed;
	logic [31:0] shifted;
	logic signed [17:0] year_sum;
	logic [15:0] year_clamped;
	logic        year_flag;

	assign en3 = !v_s3 || res.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign cmd.ready = en1;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_year_q <= otc_pkg::BASE_YEAR_RESET;
		end else if (cfg.valid) begin
			base_year_q <= cfg.base_year;
		end
	end

	// Stage one: pack the encode word and count its steps, or scan the decode code.
	always_comb begin
		diff       = {1'b0, cmd.year_in} - {1'b0, base_year_q};
		too_late   = !diff[16] && (diff[15:4] != 12'd0);
		steps_full = diff[16] ? (13'd0 - diff[16:4]) : 13'd0;
		steps      = (steps_full > 13'(otc_pkg::STEP_CAP)) ? otc_pkg::STEP_CAP
			: steps_full[5:0];
		offset     = too_late ? otc_pkg::OFFSET_MAX : diff[3:0];
		enc_word   = {otc_pkg::INDICATOR, offset, cmd.month_in, cmd.day_in, cmd.hour_in,
			cmd.minute_in, cmd.second_in};
		unique case (steps)
			6'd0:    enc_shamt = 6'd0;
			6'd1:    enc_shamt = otc_pkg::BIG_SHIFT;
			6'd2:    enc_shamt = otc_pkg::HALF_SHIFT;
			default: enc_shamt = steps + otc_pkg::SMALL_BASE;
		endcase

		// The highest zero with a one directly above it marks where the single-bit
		// steps stop.
		top_ones   = cmd.code_in[31:16] == otc_pkg::TOP_HALF_ONES;
		found_zero = 1'b0;
		zero_pos   = 4'd0;
		for (int i = 0; i < 15; i++) begin
			if (!cmd.code_in[i] && cmd.code_in[i + 1]) begin
				found_zero = 1'b1;
				zero_pos   = 4'(i);
			end
		end
		dec_flag = 1'b0;
		priority if (top_ones && found_zero && cmd.code_in[15]) begin
			dec_shamt = 6'd30 - {2'b00, zero_pos};
			dec_n     = 6'd16 - {2'b00, zero_pos};
		end else if (top_ones && found_zero && (zero_pos >= 4'd6)) begin
			dec_shamt = 6'd22 - {2'b00, zero_pos};
			dec_n     = 6'd15 - {2'b00, zero_pos};
		end else if (top_ones && found_zero) begin
			dec_shamt = 6'd14 - {2'b00, zero_pos};
			dec_n     = 6'd14 - {2'b00, zero_pos};
		end else if (top_ones) begin
			dec_shamt = otc_pkg::STEP_CAP;
			dec_n     = otc_pkg::STEP_CAP;
			dec_flag  = 1'b1;
		end else if (cmd.code_in[31:24] == otc_pkg::PREFIX_ONES) begin
			dec_shamt = otc_pkg::BIG_SHIFT;
			dec_n     = 6'd1;
		end else begin
			dec_shamt = 6'd0;
			dec_n     = 6'd0;
		end
	end

	// Stage two: encode shifts right with ones in, decode shifts left with ones in.
	always_comb begin
		enc_signed = $signed(word_s1);
		if (op_s1 == otc_pkg::OP_DECODE) begin
			shifted = ~((~word_s1) << shamt_s1);
		end else begin
			shifted = 32'(enc_signed >>> shamt_s1);
		end
	end

	// Stage three: rebuild the year from the base, the step count and the offset.
	always_comb begin
		year_sum = $signed({2'b00, base_year_q}) - $signed({8'd0, n_s2, 4'd0})
			+ $signed({14'd0, word_s2[29:26]});
		year_flag = 1'b0;
		priority if (year_sum[17]) begin
			year_clamped = 16'd0;
			year_flag    = 1'b1;
		end else if (year_sum[16]) begin
			year_clamped = 16'hffff;
			year_flag    = 1'b1;
		end else begin
			year_clamped = year_sum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= cmd.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && cmd.valid) begin
			op_s1 <= cmd.op;
			if (cmd.op == otc_pkg::OP_DECODE) begin
				word_s1  <= cmd.code_in;
				shamt_s1 <= dec_shamt;
				n_s1     <= dec_n;
				flag_s1  <= dec_flag;
			end else begin
				word_s1  <= enc_word;
				shamt_s1 <= enc_shamt;
				n_s1     <= steps;
				flag_s1  <= too_late;
			end
		end
		if (en2 && v_s1) begin
			op_s2   <= op_s1;
			word_s2 <= shifted;
			n_s2    <= n_s1;
			flag_s2 <= flag_s1;
		end
		if (en3 && v_s2) begin
			op_s3 <= op_s2;
			if (op_s2 == otc_pkg::OP_DECODE) begin
				code_s3   <= 32'd0;
				year_s3   <= year_clamped;
				month_s3  <= word_s2[25:22];
				day_s3    <= word_s2[21:17];
				hour_s3   <= word_s2[16:12];
				minute_s3 <= word_s2[11:6];
				second_s3 <= word_s2[5:0];
				flag_s3   <= flag_s2 || year_flag;
			end else begin
				code_s3   <= word_s2;
				year_s3   <= 16'd0;
				month_s3  <= 4'd0;
				day_s3    <= 5'd0;
				hour_s3   <= 5'd0;
				minute_s3 <= 6'd0;
				second_s3 <= 6'd0;
				flag_s3   <= flag_s2;
			end
		end
	end

	assign res.valid        = v_s3;
	assign res.code_out     = code_s3;
	assign res.year_out     = year_s3;
	assign res.month_out    = month_s3;
	assign res.day_out      = day_s3;
	assign res.hour_out     = hour_s3;
	assign res.minute_out   = minute_s3;
	assign res.second_out   = second_s3;
	assign res.out_of_range = flag_s3;

	`OTC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, cmd.valid && cmd.ready, v_s1)
	`OTC_ASSERT_NEXT(a_s1_moves_on, clk, arst_n, v_s1 && en2, v_s2)
	`OTC_ASSERT_SAME(a_encode_top_bit, clk, arst_n, v_s3 && (op_s3 == otc_pkg::OP_ENCODE), code_s3[31])
	`OTC_ASSERT_SAME(a_decode_cap_flags, clk, arst_n, v_s2 && (op_s2 == otc_pkg::OP_DECODE) && (n_s2 == otc_pkg::STEP_CAP), flag_s2)

endmodule

// ===== verif/tb_orderable_timestamp_codec.sv =====
// Self-checking testbench for the orderable timestamp codec: directed and random beats.
module tb_orderable_timestamp_codec;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int YEAR_STEP = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int BEATS_PER_PHASE = 240;
	localparam int LONG_HOLD_CYCLES = 400;

	typedef struct packed {
		logic        op;
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [31:0] code;
	} cmd_beat_t;

	typedef struct packed {
		logic [31:0] code;
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        oor;
	} conv_beat_t;

	class codec_scoreboard;
		logic [15:0] base_year;
		conv_beat_t  want_q[$];
		int          errors;

		function new();
			base_year = otc_pkg::BASE_YEAR_RESET;
			errors = 0;
		endfunction

		function logic [31:0] pack_code(cmd_beat_t c, output logic flag);
			int d;
			int steps;
			logic [3:0] off;
			logic [31:0] r;
			d = int'(c.year) - int'(base_year);
			steps = 0;
			flag = 1'b0;
			if (d > 15) begin
				off = otc_pkg::OFFSET_MAX;
				flag = 1'b1;
			end else if (d < 0) begin
				steps = (-d + 15) / YEAR_STEP;
				off = 4'(d + steps * YEAR_STEP);
			end else begin
				off = 4'(d);
			end
			r = {otc_pkg::INDICATOR, off, c.month, c.day, c.hour, c.minute, c.second};
			if (steps > int'(otc_pkg::STEP_CAP))
				steps = int'(otc_pkg::STEP_CAP);
			for (int i = 0; i < steps; i++) begin
				if (r[31:16] == otc_pkg::TOP_HALF_ONES)
					r = {1'b1, r[31:1]};
				else
					r = {otc_pkg::PREFIX_ONES, r[31:8]};
			end
			return r;
		endfunction

		function conv_beat_t convert(cmd_beat_t c);
			conv_beat_t r;
			logic flag;
			logic [31:0] ts;
			int n;
			int yr;
			bit entered;
			r = '0;
			if (c.op == otc_pkg::OP_ENCODE) begin
				r.code = pack_code(c, flag);
				r.oor = flag;
				return r;
			end
			ts = c.code;
			n = 0;
			entered = 1'b0;
			flag = 1'b0;
			if (ts[31:16] == otc_pkg::TOP_HALF_ONES) begin
				entered = 1'b1;
				while (ts[15:14] != otc_pkg::INDICATOR && n < int'(otc_pkg::STEP_CAP)) begin
					ts = {ts[30:0], 1'b1};
					n++;
				end
			end
			while (ts[31:24] == otc_pkg::PREFIX_ONES && n < int'(otc_pkg::STEP_CAP)) begin
				ts = {ts[23:0], otc_pkg::PREFIX_ONES};
				n++;
			end
			if (n >= int'(otc_pkg::STEP_CAP)) begin
				if (entered && ts[15:14] != otc_pkg::INDICATOR)
					flag = 1'b1;
				if (ts[31:24] == otc_pkg::PREFIX_ONES)
					flag = 1'b1;
			end
			r.second = ts[5:0];
			r.minute = ts[11:6];
			r.hour = ts[16:12];
			r.day = ts[21:17];
			r.month = ts[25:22];
			yr = int'(base_year) - n * YEAR_STEP + int'(ts[29:26]);
			if (yr < 0) begin
				yr = 0;
				flag = 1'b1;
			end else if (yr > 65535) begin
				yr = 65535;
				flag = 1'b1;
			end
			r.year = 16'(yr);
			r.oor = flag;
			return r;
		endfunction

		function void note_command(cmd_beat_t c);
			want_q.push_back(convert(c));
		endfunction

		function void check_conversion(conv_beat_t got);
			conv_beat_t want;
			if (want_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, actual code %h year %h fields %h %h %h %h %h oor %b",
					$time, got.code, got.year, got.month, got.day, got.hour, got.minute,
					got.second, got.oor);
				return;
			end
			want = want_q.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: mismatch, expected code %h year %h fields %h %h %h %h %h oor %b",
					$time, want.code, want.year, want.month, want.day, want.hour,
					want.minute, want.second, want.oor);
				$display("%0t: mismatch, actual   code %h year %h fields %h %h %h %h %h oor %b",
					$time, got.code, got.year, got.month, got.day, got.hour, got.minute,
					got.second, got.oor);
			end
		endfunction

		function int pending();
			return want_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycles = 0;
	bit   src_idle_on = 1'b1;
	bit   sink_idle_on = 1'b1;
	bit   long_hold_req = 1'b0;
	bit   long_hold_done = 1'b0;
	int   ready_gap = 0;

	codec_scoreboard sb = new();

	otc_cmd_if cmd_if();
	otc_res_if res_if();
	otc_cfg_if cfg_if();

	orderable_timestamp_codec DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
				sb.check_conversion({res_if.code_out, res_if.year_out, res_if.month_out,
					res_if.day_out, res_if.hour_out, res_if.minute_out, res_if.second_out,
					res_if.out_of_range});
			if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1)
				sb.note_command({cmd_if.op, cmd_if.year_in, cmd_if.month_in, cmd_if.day_in,
					cmd_if.hour_in, cmd_if.minute_in, cmd_if.second_in, cmd_if.code_in});
			if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)
				sb.base_year = cfg_if.base_year;
		end
	end

	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !long_hold_done) begin
				long_hold_done = 1'b1;
				ready_gap = LONG_HOLD_CYCLES;
			end
			if (ready_gap > 0) begin
				res_if.ready <= 1'b0;
				ready_gap--;
			end else begin
				res_if.ready <= 1'b1;
				if (sink_idle_on && $urandom_range(0, 7) == 0)
					ready_gap = $urandom_range(1, 12);
			end
		end
	end

	task automatic drive_cmd(input cmd_beat_t c);
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			cmd_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.op <= c.op;
		cmd_if.year_in <= c.year;
		cmd_if.month_in <= c.month;
		cmd_if.day_in <= c.day;
		cmd_if.hour_in <= c.hour;
		cmd_if.minute_in <= c.minute;
		cmd_if.second_in <= c.second;
		cmd_if.code_in <= c.code;
		do @(posedge clk); while (cmd_if.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd_if.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() > 0);
		@(negedge clk);
	endtask

	task automatic write_base(input logic [15:0] value);
		wait_drained();
		cfg_if.valid <= 1'b1;
		cfg_if.base_year <= value;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic cmd_beat_t random_fields();
		cmd_beat_t c;
		c.op = otc_pkg::OP_ENCODE;
		c.year = 16'($urandom);
		c.month = 4'($urandom);
		c.day = 5'($urandom);
		c.hour = 5'($urandom);
		c.minute = 6'($urandom);
		c.second = 6'($urandom);
		c.code = $urandom;
		return c;
	endfunction

	task automatic encode_beat(input int y, input int mo, input int dy, input int h,
		input int mi, input int s);
		cmd_beat_t c;
		c = random_fields();
		c.year = 16'(y);
		c.month = 4'(mo);
		c.day = 5'(dy);
		c.hour = 5'(h);
		c.minute = 6'(mi);
		c.second = 6'(s);
		drive_cmd(c);
	endtask

	task automatic decode_beat(input logic [31:0] code);
		cmd_beat_t c;
		c = random_fields();
		c.op = otc_pkg::OP_DECODE;
		c.code = code;
		drive_cmd(c);
	endtask

	function automatic cmd_beat_t random_cmd();
		cmd_beat_t c;
		cmd_beat_t src;
		int pick;
		int y;
		logic flag;
		c = random_fields();
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			y = int'(sb.base_year) + int'($urandom_range(0, 620)) - 600;
			if (y < 0)
				y = 0;
			if (y > 65535)
				y = 65535;
			c.year = 16'(y);
		end else if (pick < 70) begin
			src = random_fields();
			y = int'(sb.base_year) - int'($urandom_range(0, 600));
			if (y < 0)
				y = 0;
			src.year = 16'(y);
			c.op = otc_pkg::OP_DECODE;
			c.code = sb.pack_code(src, flag);
		end else if (pick < 80) begin
			c.op = otc_pkg::OP_DECODE;
			c.code[31:16] = otc_pkg::TOP_HALF_ONES;
		end else if (pick >= 90) begin
			c.op = otc_pkg::OP_DECODE;
		end
		return c;
	endfunction

	initial begin
		logic [15:0] phase_base[7];
		cmd_if.valid = 1'b0;
		cmd_if.op = otc_pkg::OP_ENCODE;
		cmd_if.year_in = '0;
		cmd_if.month_in = '0;
		cmd_if.day_in = '0;
		cmd_if.hour_in = '0;
		cmd_if.minute_in = '0;
		cmd_if.second_in = '0;
		cmd_if.code_in = '0;
		cfg_if.valid = 1'b0;
		cfg_if.base_year = '0;
		phase_base = '{16'd0, 16'd65535, 16'd15, 16'd500, 16'd0, 16'd40000, 16'd2018};
		phase_base[4] = 16'($urandom);
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		encode_beat(2018, 0, 0, 0, 0, 0);
		encode_beat(2018, 15, 31, 31, 63, 63);
		encode_beat(2033, 1, 2, 3, 4, 5);
		encode_beat(2034, 6, 7, 8, 9, 10);
		encode_beat(65535, 15, 31, 31, 63, 63);
		encode_beat(2017, 12, 31, 23, 59, 59);
		encode_beat(2002, 1, 1, 0, 0, 0);
		encode_beat(1500, 3, 4, 5, 6, 7);
		encode_beat(0, 0, 0, 0, 0, 0);
		decode_beat(32'h0000_0000);
		decode_beat(32'hffff_ffff);
		decode_beat(32'h8000_0000);
		decode_beat(32'h7fff_ffff);
		decode_beat(32'hffff_8000);
		decode_beat(32'hffff_c000);
		decode_beat(32'hff80_0000);
		decode_beat(32'hbfff_ffff);

		write_base(16'd0);
		encode_beat(0, 9, 9, 9, 9, 9);
		decode_beat(32'hff80_0000);
		decode_beat(32'hffff_ffff);

		write_base(16'd65535);
		decode_beat(32'hbc00_0000);
		encode_beat(65535, 15, 31, 31, 63, 63);
		encode_beat(0, 0, 0, 0, 0, 0);

		for (int p = 0; p < 7; p++) begin
			write_base(phase_base[p]);
			if (p == 1)
				long_hold_req = 1'b1;
			if (p == 6) begin
				src_idle_on = 1'b0;
				sink_idle_on = 1'b0;
			end
			repeat (BEATS_PER_PHASE) drive_cmd(random_cmd());
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ===== orderable_timestamp_codec.f =====
+incdir+hdl
hdl/otc_pkg.sv
hdl/otc_if.sv
hdl/orderable_timestamp_codec.sv
verif/tb_orderable_timestamp_codec.sv
